// ===== rtl/core/rsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rsfp_pkg
// Shared types and constants of the radar serial frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rsfp_pkg;

  // Frame type bytes
  localparam logic [7:0] TYPE_DISPLAY = 8'd2;
  localparam logic [7:0] TYPE_TGT_A   = 8'd82;
  localparam logic [7:0] TYPE_TGT_B   = 8'd89;
  localparam logic [7:0] TYPE_DRV_ID  = 8'd67;
  localparam logic [7:0] TYPE_SKIP_S  = 8'd34;
  localparam logic [7:0] TYPE_SKIP_L  = 8'd36;

  // Frame geometry
  localparam logic [5:0] DISPLAY_HDR_LEN  = 6'd2;
  localparam logic [5:0] SKIP_S_LEN       = 6'd2;
  localparam logic [5:0] SKIP_L_LEN       = 6'd6;
  localparam logic [7:0] MAX_TARGETS      = 8'd7;
  localparam logic [5:0] BYTES_PER_TARGET = 6'd8;
  localparam logic [7:0] ID_LEN_MASK      = 8'h07;
  localparam logic [5:0] MAX_POSITION     = 6'd59;

  // Frame kind codes
  localparam logic [1:0] KIND_DISPLAY = 2'd0;
  localparam logic [1:0] KIND_TGT_A   = 2'd1;
  localparam logic [1:0] KIND_TGT_B   = 2'd2;
  localparam logic [1:0] KIND_DRV_ID  = 2'd3;

  // Frame status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CSUM  = 2'd1;
  localparam logic [1:0] ST_COUNT = 2'd2;

  // One result item
  typedef struct packed {
    logic [1:0] frame_status;
    logic       last_of_frame;
    logic [1:0] frame_kind;
    logic [5:0] byte_position;
    logic [7:0] data_byte;
  } rsfp_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/rsfp_in_stage.sv =====
// ----------------------------------------------------------------------------
// rsfp_in_stage
// Input register: captures one received byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfp_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  output logic            s_ready_o,
  input  wire logic [7:0] s_byte_i,
  input  wire logic       take_i,
  output logic            valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  // Accept when empty or when the held byte leaves this cycle
  assign s_ready_o = !valid_q || take_i;
  assign accept    = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= s_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

// ===== rtl/core/rsfp_parser.sv =====
// ----------------------------------------------------------------------------
// rsfp_parser
// Frame state machine: consumes one byte per step and forms the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfp_parser
  import rsfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output logic            res_valid_o,
  output rsfp_result_t    res_o
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SKIP,
    PH_BODY,
    PH_FRAMENO,
    PH_COUNT,
    PH_IDSTAT,
    PH_CSUM
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [1:0] kind_q, kind_d;
  logic [5:0] remain_q, remain_d;
  logic [7:0] sum_q, sum_d;
  logic [5:0] pos_q, pos_d;

  logic       emit;
  logic       last;
  logic [1:0] status;
  logic [7:0] sum_base;
  logic [5:0] pos_base;
  logic [5:0] remain_dec;
  logic [5:0] body_len;

  // Count down toward zero, saturating
  assign remain_dec = (remain_q != 6'd0) ? remain_q - 6'd1 : 6'd0;
  assign body_len   = {3'b000, byte_i[2:0]} * BYTES_PER_TARGET;

  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    remain_d = remain_q;
    emit     = 1'b0;
    last     = 1'b0;
    status   = ST_OK;
    sum_base = sum_q;
    pos_base = pos_q;

    case (phase_q)
      PH_SKIP: begin
        remain_d = remain_dec;
        if (remain_dec == 6'd0) begin
          phase_d = PH_HUNT;
        end
      end
      PH_BODY: begin
        emit     = 1'b1;
        remain_d = remain_dec;
        if (remain_dec == 6'd0) begin
          phase_d = PH_CSUM;
        end
      end
      PH_FRAMENO: begin
        emit    = 1'b1;
        phase_d = PH_COUNT;
      end
      PH_COUNT: begin
        emit = 1'b1;
        if (byte_i > MAX_TARGETS) begin
          last    = 1'b1;
          status  = ST_COUNT;
          phase_d = PH_HUNT;
        end else begin
          remain_d = body_len;
          phase_d  = (byte_i[2:0] == 3'd0) ? PH_CSUM : PH_BODY;
        end
      end
      PH_IDSTAT: begin
        emit     = 1'b1;
        remain_d = {3'b000, byte_i[2:0] & ID_LEN_MASK[2:0]};
        phase_d  = (byte_i[2:0] == 3'd0) ? PH_CSUM : PH_BODY;
      end
      PH_CSUM: begin
        emit    = 1'b1;
        last    = 1'b1;
        status  = (sum_q + byte_i == 8'd0) ? ST_OK : ST_CSUM;
        phase_d = PH_HUNT;
      end
      default: begin
        // Hunt for a type byte; a new frame restarts sum and position
        phase_d  = PH_HUNT;
        sum_base = 8'd0;
        pos_base = 6'd0;
        case (byte_i)
          TYPE_DISPLAY: begin
            emit     = 1'b1;
            kind_d   = KIND_DISPLAY;
            remain_d = DISPLAY_HDR_LEN;
            phase_d  = PH_BODY;
          end
          TYPE_TGT_A: begin
            emit    = 1'b1;
            kind_d  = KIND_TGT_A;
            phase_d = PH_FRAMENO;
          end
          TYPE_TGT_B: begin
            emit    = 1'b1;
            kind_d  = KIND_TGT_B;
            phase_d = PH_FRAMENO;
          end
          TYPE_DRV_ID: begin
            emit    = 1'b1;
            kind_d  = KIND_DRV_ID;
            phase_d = PH_IDSTAT;
          end
          TYPE_SKIP_S: begin
            remain_d = SKIP_S_LEN;
            phase_d  = PH_SKIP;
          end
          TYPE_SKIP_L: begin
            remain_d = SKIP_L_LEN;
            phase_d  = PH_SKIP;
          end
          default: begin
            // drop the byte
          end
        endcase
      end
    endcase

    // Accumulate the frame sum and advance the position on emitted bytes
    sum_d = emit ? sum_base + byte_i : sum_base;
    pos_d = emit ? pos_base + 6'd1 : pos_base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      kind_q   <= KIND_DISPLAY;
      remain_q <= 6'd0;
      sum_q    <= 8'd0;
      pos_q    <= 6'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      remain_q <= remain_d;
      sum_q    <= sum_d;
      pos_q    <= pos_d;
    end
  end

  // Form the result item
  assign res_valid_o          = step_i && emit;
  assign res_o.data_byte      = byte_i;
  assign res_o.byte_position  = pos_base;
  assign res_o.frame_kind     = kind_d;
  assign res_o.last_of_frame  = last;
  assign res_o.frame_status   = status;

endmodule

`default_nettype wire

// ===== rtl/core/rsfp_out_stage.sv =====
// ----------------------------------------------------------------------------
// rsfp_out_stage
// Result register: holds one result item until the downstream takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfp_out_stage
  import rsfp_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic          res_valid_i,
  input  wire rsfp_result_t  res_i,
  output logic               can_load_o,
  output logic               m_valid_o,
  input  wire logic          m_ready_i,
  output rsfp_result_t       m_res_o
);

  logic         valid_q, valid_d;
  rsfp_result_t res_q;

  // Free when empty or when the held item leaves this cycle
  assign can_load_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (can_load_o) begin
      valid_d = step_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload
  always_ff @(posedge clk_i) begin
    if (can_load_o && step_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_res_o   = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/radar_serial_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// radar_serial_frame_parser_top
// Radar serial frame parser: tags the bytes of kept frames with position,
// kind and status.
// ----------------------------------------------------------------------------
// The block takes one received byte per transaction and can take a new byte
// in every clock cycle. Each byte passes an input register, one step of the
// frame state machine and a result register, so a result transaction is
// offered once its byte has left the input register and passed that step.
// Bytes of skipped frames and bytes outside any frame produce no result.
// The output register frees itself in the cycle its transaction completes,
// so full rate holds as long as the downstream keeps m_axis_tready high;
// when it stalls, input is held off after one byte.
`default_nettype none

module radar_serial_frame_parser_top
  import rsfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] data_byte, [13:8] byte_position, [15:14] 0
  output logic             m_axis_tlast,   // last_of_frame
  output logic [3:0]       m_axis_tuser    // [1:0] frame_kind, [3:2] frame_status
);

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         can_load;
  logic         step;
  logic         res_valid;
  rsfp_result_t res;
  rsfp_result_t out_res;

  // Advance one byte when the result register can take its result
  assign step = in_valid && can_load;

  rsfp_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_byte_i  (s_axis_tdata),
    .take_i    (step),
    .valid_o   (in_valid),
    .byte_o    (in_byte)
  );

  rsfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rsfp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .can_load_o  (can_load),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_res_o     (out_res)
  );

  // Pack the result transaction
  assign m_axis_tdata = {2'b00, out_res.byte_position, out_res.data_byte};
  assign m_axis_tlast = out_res.last_of_frame;
  assign m_axis_tuser = {out_res.frame_status, out_res.frame_kind};

  // A non-ok status only ever marks the final byte of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.frame_status != ST_OK) |-> res.last_of_frame)
    else $error("frame status set on a byte that is not last");

  // Position zero is always a recognized type byte and never ends a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.byte_position == 6'd0) |->
      (!res.last_of_frame &&
       (res.data_byte == TYPE_DISPLAY || res.data_byte == TYPE_TGT_A ||
        res.data_byte == TYPE_TGT_B || res.data_byte == TYPE_DRV_ID)))
    else $error("frame start without a kept type byte");

  // Frames never grow past the longest layout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res.byte_position <= MAX_POSITION))
    else $error("byte position beyond frame length");

  // Hold a pending result steady while the downstream stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("pending result lost or changed under stall");

endmodule

`default_nettype wire
